### rtl/tgc_pkg.sv
`timescale 1ns / 1ps

package tgc_pkg;

    // Field widths of the event and gesture channels.
    localparam int unsigned TIME_W = 32;
    localparam int unsigned POS_W  = 16;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned GEST_W = 3;
    localparam int unsigned TALLY_W = 2;

    // Event kinds on the input channel.
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DOWN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UP   = 2'd2;

    // Gesture codes on the output channel.
    localparam logic [GEST_W-1:0] G_SWIPE_START  = 3'd0;
    localparam logic [GEST_W-1:0] G_SWIPE_UPDATE = 3'd1;
    localparam logic [GEST_W-1:0] G_SWIPE_END    = 3'd2;
    localparam logic [GEST_W-1:0] G_SINGLE_TAP   = 3'd3;
    localparam logic [GEST_W-1:0] G_DOUBLE_TAP   = 3'd4;
    localparam logic [GEST_W-1:0] G_HELD_START   = 3'd5;
    localparam logic [GEST_W-1:0] G_HELD_END     = 3'd6;

    // Tap count values; the count saturates at the held-tap limit.
    localparam logic [TALLY_W-1:0] TALLY_NONE   = 2'd0;
    localparam logic [TALLY_W-1:0] TALLY_SINGLE = 2'd1;
    localparam logic [TALLY_W-1:0] TALLY_DOUBLE = 2'd2;
    localparam logic [TALLY_W-1:0] TALLY_LIMIT  = 2'd3;

    // Configuration register map.
    localparam int unsigned          APB_ADDR_W    = 3;
    localparam logic [TIME_W-1:0]    WINDOW_RESET  = 32'd100;

    // Classifier state carried from one event to the next.
    typedef struct packed {
        logic [TIME_W-1:0]  press_time;
        logic [TIME_W-1:0]  release_time;
        logic [TALLY_W-1:0] tap_tally;
        logic               finger_down;
        logic               swipe_active;
        logic               held_tap_active;
    } t_state;

    // Outcome of one event: whether a gesture is reported, and which.
    typedef struct packed {
        logic              emit;
        logic [GEST_W-1:0] gesture;
    } t_result;

endpackage

### rtl/tgc_evt_if.sv
`timescale 1ns / 1ps

// Touch event channel: one request per tick, touch down or touch up.
interface tgc_evt_if;
    import tgc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] time_now;
    logic [POS_W-1:0]  x_pos;
    logic [POS_W-1:0]  y_pos;

    modport source (output valid, output mode, output time_now, output x_pos,
                    output y_pos, input ready);
    modport sink   (input valid, input mode, input time_now, input x_pos,
                    input y_pos, output ready);
endinterface

### rtl/tgc_gst_if.sv
`timescale 1ns / 1ps

// Gesture channel: one request per reported gesture.
interface tgc_gst_if;
    import tgc_pkg::*;

    logic              valid;
    logic              ready;
    logic [GEST_W-1:0] gesture;
    logic [POS_W-1:0]  gesture_x;
    logic [POS_W-1:0]  gesture_y;

    modport source (output valid, output gesture, output gesture_x,
                    output gesture_y, input ready);
    modport sink   (input valid, input gesture, input gesture_x,
                    input gesture_y, output ready);
endinterface

### rtl/tgc_step.sv
`timescale 1ns / 1ps

// Decision logic for one event: next classifier state and the gesture it
// reports, if any. Purely combinational.
module tgc_step (
    input  tgc_pkg::t_state                  i_state,
    input  logic [tgc_pkg::TIME_W-1:0]       i_window,
    input  logic [tgc_pkg::MODE_W-1:0]       i_mode,
    input  logic [tgc_pkg::TIME_W-1:0]       i_time_now,
    output tgc_pkg::t_state                  o_state,
    output tgc_pkg::t_result                 o_result
);
    import tgc_pkg::*;

    logic [TIME_W-1:0]  since_press;
    logic [TIME_W-1:0]  since_release;
    logic               press_late;
    logic               release_late;
    logic [TALLY_W-1:0] tally_up;
    logic               held_start;

    // Elapsed times wrap modulo 2^32.
    assign since_press   = i_time_now - i_state.press_time;
    assign since_release = i_time_now - i_state.release_time;
    assign press_late    = since_press > i_window;
    assign release_late  = since_release > i_window;

    // Tap count on a quick release, saturating at the limit.
    assign tally_up   = (i_state.tap_tally == TALLY_LIMIT) ? TALLY_LIMIT
                                                           : i_state.tap_tally + 2'd1;
    assign held_start = !press_late && (tally_up == TALLY_LIMIT)
                        && !i_state.held_tap_active;

    always_comb begin
        o_state          = i_state;
        o_result.emit    = 1'b0;
        o_result.gesture = G_SWIPE_START;
        unique case (i_mode)
            MODE_TICK: begin
                if (i_state.finger_down) begin
                    // A long press with no pending taps is a swipe.
                    if (press_late && (i_state.tap_tally == TALLY_NONE)) begin
                        o_result.emit = 1'b1;
                        if (!i_state.swipe_active) begin
                            o_state.swipe_active = 1'b1;
                            o_result.gesture     = G_SWIPE_START;
                        end else begin
                            o_result.gesture = G_SWIPE_UPDATE;
                        end
                    end
                end else if (release_late) begin
                    // Finger has stayed up long enough: report pending taps.
                    if (i_state.held_tap_active) begin
                        o_state.held_tap_active = 1'b0;
                        o_state.tap_tally       = TALLY_NONE;
                        o_result.emit           = 1'b1;
                        o_result.gesture        = G_HELD_END;
                    end else if (i_state.tap_tally != TALLY_NONE) begin
                        o_state.tap_tally = TALLY_NONE;
                        if (i_state.tap_tally == TALLY_SINGLE) begin
                            o_result.emit    = 1'b1;
                            o_result.gesture = G_SINGLE_TAP;
                        end else if (i_state.tap_tally == TALLY_DOUBLE) begin
                            o_result.emit    = 1'b1;
                            o_result.gesture = G_DOUBLE_TAP;
                        end
                    end
                end
            end
            MODE_DOWN: begin
                o_state.press_time  = i_time_now;
                o_state.finger_down = 1'b1;
            end
            MODE_UP: begin
                o_state.release_time = i_time_now;
                o_state.finger_down  = 1'b0;
                o_state.swipe_active = 1'b0;
                if (!press_late) begin
                    o_state.tap_tally = tally_up;
                end
                // A held tap start takes precedence over a swipe end.
                if (held_start) begin
                    o_state.held_tap_active = 1'b1;
                    o_result.emit           = 1'b1;
                    o_result.gesture        = G_HELD_START;
                end else if (i_state.swipe_active) begin
                    o_result.emit    = 1'b1;
                    o_result.gesture = G_SWIPE_END;
                end
            end
            default: begin
                // Unused event kind: no state change, no gesture.
            end
        endcase
    end

endmodule

### rtl/touch_gesture_classifier.sv
`timescale 1ns / 1ps

// Touch gesture classifier. Takes a stream of tick, touch-down and touch-up
// events with timestamps and coordinates, and reports swipes, single and
// double taps, and held taps with the coordinates of the event that caused
// them. One event is accepted every cycle unless a waiting gesture stalls
// the pipeline; each passes an input register, the decision logic (two
// 32-bit timestamp subtractions and compares against tap_window), and an
// output register that offers the gesture. An event that reports nothing
// produces no output request. While a gesture waits to be taken, one more
// event can enter the input register, and the input stalls after that.
// tap_window (reset 100 ticks) sits at APB byte address 0 and should be
// written only while the block is idle.
module touch_gesture_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tgc_evt_if.sink                         i_evt,
    tgc_gst_if.source                       o_gst,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tgc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import tgc_pkg::*;

    logic [TIME_W-1:0] r_window;
    logic              window_sel;

    logic              r_s1_valid;
    logic [MODE_W-1:0] r_s1_mode;
    logic [TIME_W-1:0] r_s1_time;
    logic [POS_W-1:0]  r_s1_x;
    logic [POS_W-1:0]  r_s1_y;

    t_state            r_state;
    t_state            n_state;
    t_result           step_result;

    logic              r_out_valid;
    logic [GEST_W-1:0] r_out_gesture;
    logic [POS_W-1:0]  r_out_x;
    logic [POS_W-1:0]  r_out_y;

    logic              advance;
    logic              s1_fire;

    // Configuration register: only the word at address 0 is implemented.
    assign pready     = 1'b1;
    assign window_sel = (paddr[APB_ADDR_W-1] == 1'b0);
    assign prdata     = window_sel ? r_window : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (psel && penable && pwrite && window_sel) begin
            r_window <= pwdata;
        end
    end

    // Pipeline moves whenever the output register is empty or being drained.
    assign advance     = !r_out_valid || o_gst.ready;
    assign s1_fire     = r_s1_valid && advance;
    assign i_evt.ready = !r_s1_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_s1_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.ready && i_evt.valid) begin
            r_s1_mode <= i_evt.mode;
            r_s1_time <= i_evt.time_now;
            r_s1_x    <= i_evt.x_pos;
            r_s1_y    <= i_evt.y_pos;
        end
    end

    // Decision logic for the registered event.
    tgc_step u_step (
        .i_state    (r_state),
        .i_window   (r_window),
        .i_mode     (r_s1_mode),
        .i_time_now (r_s1_time),
        .o_state    (n_state),
        .o_result   (step_result)
    );

    // Classifier state commits as the event leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid && step_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && step_result.emit) begin
            r_out_gesture <= step_result.gesture;
            r_out_x       <= r_s1_x;
            r_out_y       <= r_s1_y;
        end
    end

    assign o_gst.valid     = r_out_valid;
    assign o_gst.gesture   = r_out_gesture;
    assign o_gst.gesture_x = r_out_x;
    assign o_gst.gesture_y = r_out_y;

endmodule
